>>> rtl/core/hash_cache_generation_evict_defines.svh
// Assertion macros used by the checker file of the hash cache.
// No dependencies.
`ifndef HASH_CACHE_GENERATION_EVICT_DEFINES_SVH
`define HASH_CACHE_GENERATION_EVICT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define HCGE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define HCGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/core/hcge_pkg.sv
// Shared types and constants of the hash cache.
// No dependencies.
package hcge_pkg;
    localparam logic [31:0] HASH_MUL = 32'd2654435761;
    localparam int KEY_W = 21;
    localparam int AGE_W = 32;
    localparam int EVICT_W = 12;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_PROBE_RD, ST_PROBE_CHK,
        ST_MIN_RD, ST_MIN_CHK, ST_THR, ST_EV_RD, ST_EV_CHK, ST_DONE
    } hcge_state_t;

    typedef struct packed {
        logic clr_init;      // start clearing pass at slot 0
        logic clr_step;      // clear one slot, advance
        logic load_item;     // capture input item
        logic hash;          // compute home slot
        logic probe_start;   // index <= home, count <= 0
        logic probe_adv;     // index++, count++
        logic rd;            // issue read at index
        logic hit_write;     // stamp age on hit
        logic ins_write;     // write new entry
        logic scan_start;    // index <= 0, min <= age_counter
        logic scan_adv;      // index++
        logic min_upd;       // fold read age into oldest
        logic thr_calc;      // compute threshold and limit
        logic ev_clear;      // clear read entry (valid off)
        logic res_miss;      // produce not-found result
        logic res_hit;       // produce found result
        logic out_load;      // load output register
    } hcge_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_insert;
        logic need_evict;
        logic rd_valid;
        logic rd_match;
        logic probe_last;
        logic scan_last;
        logic ev_take;
        logic ev_done;
    } hcge_sts_t;
endpackage

>>> rtl/core/hash_cache_generation_evict.sv
// Top level of the hash cache: controller plus datapath.
// Depends on hcge_pkg, hcge_ctrl, hcge_datapath.
//
// Usage: an item (action, key, payload_in) enters on in_valid/in_ready; one
// result (found, slot_index, payload_out, evicted_count) leaves on
// out_valid/out_ready. Lookup stops at the first empty or matching slot;
// insert claims the first empty probe slot, evicting old entries first when
// three quarters full.
// The slot memory is single-port (one read or write a cycle).
// One item is worked at a time; the next is taken once the previous result
// has left the output register.
// Reset: a clearing pass writes every slot (8192 at default) empty, during
// which in_ready stays low.
// Stall: a result waiting on out_ready holds; no new item is taken meanwhile.
module hash_cache_generation_evict
    import hcge_pkg::*;
#(
    parameter int INDEX_BITS = 13,
    parameter int PAYLOAD_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     action,
    input  logic [KEY_W-1:0]         key,
    input  logic [PAYLOAD_WIDTH-1:0] payload_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     found,
    output logic [INDEX_BITS-1:0]    slot_index,
    output logic [PAYLOAD_WIDTH-1:0] payload_out,
    output logic [EVICT_W-1:0]       evicted_count
);
    hcge_cmd_t cmd;
    hcge_sts_t sts;

    hcge_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
    );

    hcge_datapath #(.INDEX_BITS(INDEX_BITS), .PAYLOAD_WIDTH(PAYLOAD_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .action(action),
        .key(key), .payload_in(payload_in), .found(found),
        .slot_index(slot_index), .payload_out(payload_out),
        .evicted_count(evicted_count)
    );
endmodule

>>> rtl/core/hcge_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module hcge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

>>> rtl/core/hcge_datapath.sv
// Datapath of the hash cache: slot memory, probe/scan counters, ages.
// Depends on hcge_pkg and hcge_ram.
module hcge_datapath
    import hcge_pkg::*;
#(
    parameter int INDEX_BITS = 13,
    parameter int PAYLOAD_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hcge_cmd_t                cmd,
    output hcge_sts_t                sts,
    input  logic                     action,
    input  logic [KEY_W-1:0]         key,
    input  logic [PAYLOAD_WIDTH-1:0] payload_in,
    output logic                     found,
    output logic [INDEX_BITS-1:0]    slot_index,
    output logic [PAYLOAD_WIDTH-1:0] payload_out,
    output logic [EVICT_W-1:0]       evicted_count
);
    localparam int SLOTS = 1 << INDEX_BITS;
    localparam int CNT_W = INDEX_BITS + 1;
    localparam int ENT_W = 1 + KEY_W + AGE_W + PAYLOAD_WIDTH;
    localparam logic [CNT_W-1:0] FULL_LVL = CNT_W'((SLOTS * 3) / 4);

    logic                     act_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;
    logic [31:0]              prod_reg;
    logic [31:0]              prod;
    logic [INDEX_BITS-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         live_reg;
    logic [AGE_W-1:0]         age_reg;
    logic [AGE_W-1:0]         min_reg;
    logic [AGE_W-1:0]         thr_reg;
    logic [CNT_W-1:0]         lim_reg;
    logic [EVICT_W-1:0]       ev_reg;
    logic                     found_reg;
    logic [INDEX_BITS-1:0]    slot_reg;
    logic [PAYLOAD_WIDTH-1:0] pout_reg;

    logic                     we;
    logic [ENT_W-1:0]         wdata, rdata;
    logic                     r_valid;
    logic [KEY_W-1:0]         r_key;
    logic [AGE_W-1:0]         r_age;
    logic [PAYLOAD_WIDTH-1:0] r_pay;
    logic [AGE_W-1:0]         diff;

    assign {r_valid, r_key, r_age, r_pay} = rdata;

    // Valid bit lives in the same word; clearing pass wipes it after reset.
    always_comb
    begin
        we = 1'b0;
        wdata = rdata;
        if (cmd.clr_step)
        begin
            we = 1'b1;
            wdata = '0;
        end
        else if (cmd.hit_write)
        begin
            we = 1'b1;
            wdata = {1'b1, r_key, age_reg + AGE_W'(1), r_pay};
        end
        else if (cmd.ins_write)
        begin
            we = 1'b1;
            wdata = {1'b1, key_reg, age_reg + AGE_W'(1), pay_reg};
        end
        else if (cmd.ev_clear)
        begin
            we = 1'b1;
            wdata = {1'b0, r_key, r_age, r_pay};
        end
    end

    hcge_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_slots (
        .clk(clk), .we(we), .addr(idx_reg), .wdata(wdata), .rdata(rdata)
    );

    assign diff = age_reg - min_reg;
    assign prod = 32'(key_reg) * HASH_MUL;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.clr_init || cmd.scan_start)
            idx_next = '0;
        else if (cmd.probe_start)
            idx_next = cmd.hash ? prod[31 -: INDEX_BITS] : prod_reg[31 -: INDEX_BITS];
        else if (cmd.clr_step || cmd.probe_adv || cmd.scan_adv)
            idx_next = idx_reg + INDEX_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cnt_reg <= '0;
            live_reg <= '0;
            age_reg <= '0;
            ev_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.probe_start || cmd.scan_start)
                cnt_reg <= '0;
            else if (cmd.probe_adv)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (cmd.load_item)
                ev_reg <= '0;
            else if (cmd.ev_clear)
                ev_reg <= ev_reg + EVICT_W'(1);
            if (cmd.hit_write || cmd.ins_write)
                age_reg <= age_reg + AGE_W'(1);
            if (cmd.ins_write)
                live_reg <= live_reg - CNT_W'(ev_reg) + CNT_W'(1);
            else if (cmd.out_load && act_reg)
                live_reg <= live_reg - CNT_W'(ev_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            act_reg <= action;
            key_reg <= key;
            pay_reg <= payload_in;
        end
        if (cmd.hash)
            prod_reg <= prod;
        if (cmd.scan_start)
            min_reg <= age_reg;
        else if (cmd.min_upd && r_valid && r_age < min_reg)
            min_reg <= r_age;
        if (cmd.thr_calc)
        begin
            thr_reg <= min_reg + (diff >> 1);
            lim_reg <= live_reg >> 2;
        end
        if (cmd.out_load)
        begin
            found_reg <= cmd.res_hit;
            slot_reg <= cmd.res_hit ? idx_reg : '0;
            pout_reg <= act_reg ? pay_reg : (cmd.res_hit ? r_pay : '0);
        end
    end

    // Live count is reduced at result time; compare ahead for need_evict.
    always_comb
    begin
        sts.clr_last = (idx_reg == INDEX_BITS'(SLOTS - 1));
        sts.is_insert = act_reg;
        sts.need_evict = (live_reg >= FULL_LVL);
        sts.rd_valid = r_valid;
        sts.rd_match = (r_key == key_reg);
        sts.probe_last = (cnt_reg == CNT_W'(SLOTS - 1));
        sts.scan_last = (idx_reg == INDEX_BITS'(SLOTS - 1));
        sts.ev_take = r_valid && (r_age <= thr_reg);
        sts.ev_done = (CNT_W'(ev_reg) >= lim_reg);
    end

    assign found = found_reg;
    assign slot_index = slot_reg;
    assign payload_out = pout_reg;
    assign evicted_count = ev_reg;
endmodule

>>> rtl/core/hcge_ctrl.sv
// Controller state machine of the hash cache.
// Depends on hcge_pkg.
module hcge_ctrl
    import hcge_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  hcge_sts_t sts,
    output hcge_cmd_t cmd
);
    hcge_state_t state_reg, state_next;
    logic        ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (sts.clr_last) state_next = ST_IDLE;
            ST_IDLE:      if (in_valid && !ov_reg) state_next = ST_HASH;
            ST_HASH:
                if (sts.is_insert && sts.need_evict) state_next = ST_MIN_RD;
                else state_next = ST_PROBE_RD;
            ST_PROBE_RD:  state_next = ST_PROBE_CHK;
            ST_PROBE_CHK:
            begin
                priority if (sts.is_insert ? !sts.rd_valid
                                           : (!sts.rd_valid || sts.rd_match))
                    state_next = ST_DONE;
                else if (sts.probe_last) state_next = ST_DONE;
                else state_next = ST_PROBE_RD;
            end
            ST_MIN_RD:    state_next = ST_MIN_CHK;
            ST_MIN_CHK:   state_next = sts.scan_last ? ST_THR : ST_MIN_RD;
            ST_THR:       state_next = ST_EV_RD;
            ST_EV_RD:     state_next = sts.ev_done ? ST_PROBE_RD : ST_EV_CHK;
            ST_EV_CHK:    state_next = sts.scan_last ? ST_PROBE_RD : ST_EV_RD;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs. ST_PROBE_RD after eviction needs probe_start: done in ST_THR path
    // via probe_start on leaving scan states.
    always_comb
    begin
        cmd = '0;
        ov_next = ov_reg && !out_ready;
        unique case (state_reg)
            ST_CLEAR:     cmd.clr_step = 1'b1;
            ST_IDLE:      cmd.load_item = in_valid && !ov_reg;
            ST_HASH:
            begin
                cmd.hash = 1'b1;
                if (sts.is_insert && sts.need_evict) cmd.scan_start = 1'b1;
            end
            ST_PROBE_RD:  cmd.rd = 1'b1;
            ST_PROBE_CHK:
            begin
                if (sts.is_insert ? !sts.rd_valid
                                  : (!sts.rd_valid || sts.rd_match))
                begin
                    if (sts.rd_valid || sts.is_insert)
                    begin
                        cmd.res_hit = 1'b1;
                        cmd.hit_write = !sts.is_insert;
                        cmd.ins_write = sts.is_insert;
                    end
                    else
                        cmd.res_miss = 1'b1;
                    cmd.out_load = 1'b1;
                end
                else if (sts.probe_last)
                begin
                    cmd.res_miss = 1'b1;
                    cmd.out_load = 1'b1;
                end
                else
                    cmd.probe_adv = 1'b1;
            end
            ST_MIN_RD:    cmd.rd = 1'b1;
            ST_MIN_CHK:
            begin
                cmd.min_upd = 1'b1;
                if (!sts.scan_last) cmd.scan_adv = 1'b1;
            end
            ST_THR:
            begin
                cmd.thr_calc = 1'b1;
                cmd.scan_start = 1'b1;
            end
            ST_EV_RD:     if (sts.ev_done) cmd.probe_start = 1'b1;
            ST_EV_CHK:
            begin
                cmd.ev_clear = sts.ev_take;
                if (sts.scan_last) cmd.probe_start = 1'b1;
                else cmd.scan_adv = 1'b1;
            end
            ST_DONE:      ov_next = 1'b1;
            default:      cmd = '0;
        endcase
        if (state_reg == ST_HASH && !(sts.is_insert && sts.need_evict))
            cmd.probe_start = 1'b1;
    end

    assign in_ready = (state_reg == ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
endmodule

>>> rtl/core/hcge_checker.sv
// Port-level checker for the hash cache, bound to the top level.
// Depends on hash_cache_generation_evict_defines.svh.
`include "hash_cache_generation_evict_defines.svh"
module hcge_checker #(
    parameter int INDEX_BITS = 13
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  found,
    input logic [INDEX_BITS-1:0] slot_index
);
    `HCGE_ASSERT_IMPL(a_one_item, clk, rst_n, out_valid, !in_ready, "item taken while result pending")
    `HCGE_ASSERT_IMPL(a_miss_zero, clk, rst_n, out_valid && !found, slot_index == '0, "miss with slot")
    `HCGE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(slot_index), "result dropped")
    `HCGE_ASSERT_NEXT(a_no_early, clk, rst_n, in_valid && in_ready, !out_valid, "result too early")
endmodule

bind hash_cache_generation_evict hcge_checker #(.INDEX_BITS(INDEX_BITS)) u_hcge_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .found(found),
    .slot_index(slot_index)
);
